// ===== hdl/shsm_pkg.sv =====
`timescale 1ns / 1ps

package shsm_pkg;

  // Default pattern store depth
  localparam int PATTERN_MAX_DEF = 31;

  // Field widths
  localparam int VALUE_W = 8;
  localparam int POS_W   = 5;
  localparam int LEN_W   = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CASE_INS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN  = 1'd1;

  // Input actions
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TEXT = 1'b1;

  // One input item as held in the input register
  typedef struct packed {
    logic               action;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   position;
    logic               text_first;
    logic               text_last;
  } item_t;

  // Control handed to the match core for one text byte
  typedef struct packed {
    logic step;
    logic first;
    logic last;
  } step_ctl_t;

  // Map ASCII upper case letters to lower case
  function automatic logic [VALUE_W-1:0] fold_case(input logic [VALUE_W-1:0] c);
    logic [VALUE_W-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

// ===== hdl/shsm_pattern_store.sv =====
`timescale 1ns / 1ps

module shsm_pattern_store
  import shsm_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int LW = $clog2(PATTERN_MAX + 1)
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [POS_W-1:0]       wr_pos,
  input  logic [VALUE_W-1:0]     wr_char,
  input  logic                   case_ins,
  input  logic [LW-1:0]          eff_len,
  input  logic [VALUE_W-1:0]     text_byte,
  output logic [PATTERN_MAX-1:0] mask
);

  logic [VALUE_W-1:0] chars_r [PATTERN_MAX];

  // Pattern characters, one write port; positions past the store are dropped
  always_ff @(posedge clk) begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (wr_en && int'(wr_pos) == i) begin
        chars_r[i] <= wr_char;
      end
    end
  end

  // Per-position compare, only positions below the active length count
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      mask[i] = (i < int'(eff_len)) &&
                ((text_byte == chars_r[i]) ||
                 (case_ins && fold_case(text_byte) == fold_case(chars_r[i])));
    end
  end

endmodule

// ===== hdl/shsm_match_core.sv =====
`timescale 1ns / 1ps

module shsm_match_core
  import shsm_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int LW = $clog2(PATTERN_MAX + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  step_ctl_t              ctl,
  input  logic [PATTERN_MAX-1:0] mask,
  input  logic [LW-1:0]          eff_len,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic                   out_match_end,
  output logic                   out_found,
  output logic                   out_last
);

  logic [PATTERN_MAX-1:0] vec_r;
  logic [PATTERN_MAX:0]   vec_nxt;
  logic [PATTERN_MAX-1:0] vec_base;
  logic                   found_r, found_nxt;
  logic                   hit;
  logic                   valid_r, valid_nxt;
  logic                   match_r, fnd_r, last_r;

  // Shift-And step: set bit 0, keep matching positions, shift up
  always_comb begin
    vec_base  = ctl.first ? '0 : vec_r;
    vec_nxt   = {(vec_base | {{(PATTERN_MAX-1){1'b0}}, 1'b1}) & mask, 1'b0};
    hit       = (eff_len != '0) && vec_nxt[eff_len];
    found_nxt = (ctl.first ? 1'b0 : found_r) | hit;
  end

  // Result register occupancy
  always_comb begin
    valid_nxt = valid_r;
    if (ctl.step) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  // Match state and valid flag; the bit above the store only signals a hit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vec_r   <= '0;
      found_r <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (ctl.step) begin
        vec_r   <= vec_nxt[PATTERN_MAX-1:0];
        found_r <= found_nxt;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      match_r <= hit;
      fnd_r   <= found_nxt || (eff_len == '0);
      last_r  <= ctl.last;
    end
  end

  assign out_valid     = valid_r;
  assign out_match_end = match_r;
  assign out_found     = fnd_r;
  assign out_last      = last_r;

endmodule

// ===== hdl/shift_and_substring_matcher_core.sv =====
`timescale 1ns / 1ps
// A text byte passes the input register and then the result register, which holds it until it
// transfers; a held result stalls text bytes in the input register.
// Throughput: one item per cycle unless a held result stalls; match vector update is one AND-and-shift step.
// Load items produce no result and leave the input register even while a result is held.
// Reset (rst_n, synchronous, active low) clears the match vector, found flag, configuration
// registers and valid flags; pattern characters, the held item and the result payload are not cleared.

module shift_and_substring_matcher_core
  import shsm_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_action,
  input  logic [VALUE_W-1:0]    in_value,
  input  logic [POS_W-1:0]      in_position,
  input  logic                  in_text_first,
  input  logic                  in_text_last,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_match_end,
  output logic                  out_found,
  output logic                  out_last
);

  localparam int LW = $clog2(PATTERN_MAX + 1);

  logic                   case_ins_r;
  logic [LEN_W-1:0]       pat_len_r;
  logic [LW-1:0]          eff_len;
  item_t                  item_r;
  logic                   item_v_r;
  logic                   advance;
  logic [PATTERN_MAX-1:0] mask;
  step_ctl_t              ctl;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      case_ins_r <= 1'b0;
      pat_len_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CASE_INS: case_ins_r <= cfg_data[0];
        REG_PAT_LEN:  pat_len_r  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Active length, clipped to the store depth
  always_comb begin
    if (int'(pat_len_r) < PATTERN_MAX) begin
      eff_len = LW'(pat_len_r);
    end else begin
      eff_len = LW'(PATTERN_MAX);
    end
  end

  // Input register leaves when a load, or when the result slot frees up
  assign advance  = item_v_r && ((item_r.action == ACT_LOAD) || !out_valid || out_ready);
  assign in_ready = rst_n && (!item_v_r || advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_ready) begin
      item_v_r <= in_valid;
    end else if (advance) begin
      item_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= '{action: in_action, value: in_value, position: in_position,
                  text_first: in_text_first, text_last: in_text_last};
    end
  end

  assign ctl = '{step:  advance && (item_r.action == ACT_TEXT),
                 first: item_r.text_first,
                 last:  item_r.text_last};

  shsm_pattern_store #(
    .PATTERN_MAX (PATTERN_MAX),
    .LW          (LW)
  ) u_store (
    .clk       (clk),
    .wr_en     (advance && (item_r.action == ACT_LOAD)),
    .wr_pos    (item_r.position),
    .wr_char   (item_r.value),
    .case_ins  (case_ins_r),
    .eff_len   (eff_len),
    .text_byte (item_r.value),
    .mask      (mask)
  );

  shsm_match_core #(
    .PATTERN_MAX (PATTERN_MAX),
    .LW          (LW)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .mask          (mask),
    .eff_len       (eff_len),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_match_end (out_match_end),
    .out_found     (out_found),
    .out_last      (out_last)
  );

endmodule

// ===== hdl/shsm_checker.sv =====
`timescale 1ns / 1ps

module shsm_checker
  import shsm_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  in_action,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  out_match_end,
  input logic                  out_found,
  input logic                  out_last
);

  // Stalled result holds until transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_match_end) &&
      $stable(out_found) && $stable(out_last))
    else $error("result changed while stalled");

  // Reset empties the result register
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // An occurrence ending here means the text has the pattern
  a_match_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_match_end |-> out_found)
    else $error("match without found");

  // A fresh result is traced back to a text byte input transfer
  a_rose_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_action == ACT_TEXT, 2))
    else $error("result without a text byte transfer");

endmodule

bind shift_and_substring_matcher_core shsm_checker u_shsm_checker (.*);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import shsm_pkg::*;

  localparam int RUN_ITEMS   = 850;
  localparam int SETTLE      = 6;
  localparam int CYCLE_LIMIT = 400000;
  localparam int STORE_DEPTH = PATTERN_MAX_DEF;

  // One result transfer as seen on the out_ port
  typedef struct packed {
    logic match_end;
    logic found;
    logic last;
  } verdict_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  // One line of the directed stimulus table
  typedef struct packed {
    row_kind_t             kind;
    item_t                 item;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    logic                  typed;
    verdict_t              want;
  } row_t;

  logic                  clk;
  logic                  rst_n         = 1'b0;
  logic                  cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;
  logic                  in_valid      = 1'b0;
  logic                  in_ready;
  logic                  in_action     = ACT_LOAD;
  logic [VALUE_W-1:0]    in_value      = '0;
  logic [POS_W-1:0]      in_position   = '0;
  logic                  in_text_first = 1'b0;
  logic                  in_text_last  = 1'b0;
  logic                  out_valid;
  logic                  out_ready     = 1'b0;
  logic                  out_match_end;
  logic                  out_found;
  logic                  out_last;

  // Mirror of the matcher state
  logic [VALUE_W-1:0]     pat_copy [0:STORE_DEPTH-1];
  logic [STORE_DEPTH-1:0] pat_loaded;
  logic [31:0]            hit_vec;
  logic                   found_seen;
  logic                   ci_mode;
  logic [LEN_W-1:0]       pat_len;

  verdict_t verdict_q[$];
  verdict_t want_now;
  row_t     plan[$];
  int       fail_cnt   = 0;
  int       burst_left = 0;
  int       sent_count = 0;
  int       cycle_cnt  = 0;
  int       rx_mode    = 0;
  int       rx_span    = 0;
  int       rx_tick    = 0;

  shift_and_substring_matcher_core i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_value      (in_value),
    .in_position   (in_position),
    .in_text_first (in_text_first),
    .in_text_last  (in_text_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_match_end (out_match_end),
    .out_found     (out_found),
    .out_last      (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ASCII upper case maps onto lower case by setting bit 5
  function automatic logic [7:0] lower_of(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? {c[7:6], 1'b1, c[4:0]} : c;
  endfunction

  function automatic logic [7:0] swap_case(input logic [7:0] c);
    if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
      return c ^ 8'h20;
    end
    return c;
  endfunction

  // Letters plus the codes right next to the letter ranges
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 11))
      0: return 8'h61;
      1: return 8'h41;
      2: return 8'h62;
      3: return 8'h42;
      4: return 8'h40;
      5: return 8'h5B;
      6: return 8'h60;
      7: return 8'h7B;
      8: return 8'h5A;
      9: return 8'h7A;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Shift-And step; returns 1 when the item yields a result
  function automatic bit bitap_step(input item_t it, output verdict_t v);
    logic [31:0] keep;
    logic        hit;
    keep = '0;
    v = '0;
    if (it.action == ACT_LOAD) begin
      if (it.position < STORE_DEPTH) begin
        pat_copy[it.position]   = it.value;
        pat_loaded[it.position] = 1'b1;
      end
      return 1'b0;
    end
    if (it.text_first) begin
      hit_vec    = '0;
      found_seen = 1'b0;
    end
    for (int i = 0; i < STORE_DEPTH; i++) begin
      if (i < pat_len && (it.value == pat_copy[i] ||
          (ci_mode && lower_of(it.value) == lower_of(pat_copy[i])))) begin
        keep[i] = 1'b1;
      end
    end
    hit_vec = ((hit_vec | 32'd1) & keep) << 1;
    hit = (pat_len != 0) && hit_vec[pat_len];
    if (hit) begin
      found_seen = 1'b1;
    end
    v.match_end = hit;
    v.found     = found_seen || (pat_len == 0);
    v.last      = it.text_last;
    return 1'b1;
  endfunction

  // Table row builders
  function automatic row_t txt(input logic [7:0] val, input logic first, input logic last);
    row_t r;
    r = '0;
    r.kind            = ROW_ITEM;
    r.item.action     = ACT_TEXT;
    r.item.value      = val;
    r.item.text_first = first;
    r.item.text_last  = last;
    return r;
  endfunction

  function automatic row_t txt_k(input logic [7:0] val, input logic first, input logic last,
                                 input logic m, input logic f);
    row_t r;
    r = txt(val, first, last);
    r.typed = 1'b1;
    r.want  = '{match_end: m, found: f, last: last};
    return r;
  endfunction

  function automatic row_t ld(input logic [7:0] val, input logic [POS_W-1:0] pos);
    row_t r;
    r = '0;
    r.kind          = ROW_ITEM;
    r.item.action   = ACT_LOAD;
    r.item.value    = val;
    r.item.position = pos;
    return r;
  endfunction

  function automatic row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] data);
    row_t r;
    r = '0;
    r.kind     = ROW_REG;
    r.reg_idx  = idx;
    r.reg_data = data;
    return r;
  endfunction

  // Register write; cfg_we is lowered by the next transfer or drain
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx == REG_CASE_INS) begin
      ci_mode = data[0];
    end else if (idx == REG_PAT_LEN) begin
      pat_len = data;
    end
  endtask

  // Hold the input side until every pending result has come out
  task automatic drain(input int settle);
    in_valid   <= 1'b0;
    cfg_we     <= 1'b0;
    burst_left = 0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // One input transfer, with bursts and gaps on the sender side
  task automatic send_item(input item_t it, input logic typed, input verdict_t typed_v);
    verdict_t v;
    int       gap;
    cfg_we <= 1'b0;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
    in_valid      <= 1'b1;
    in_action     <= it.action;
    in_value      <= it.value;
    in_position   <= it.position;
    in_text_first <= it.text_first;
    in_text_last  <= it.text_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    if (bitap_step(it, v)) begin
      verdict_q.push_back(typed ? typed_v : v);
    end
    if (it.action == ACT_TEXT || it.position < STORE_DEPTH) begin
      sent_count++;
    end
  endtask

  // New settings, pattern loads, then a few texts built around the pattern
  task automatic run_phase(input int phase);
    int                 new_len;
    int                 n_texts;
    int                 target;
    int                 bad;
    logic               new_ci;
    logic               refresh;
    logic               skip_first;
    logic [CFG_DATA_W-1:0] ci_data;
    logic [7:0]         c;
    logic [7:0]         chunk[$];
    item_t              it;
    case ($urandom_range(0, 9))
      0: new_len = 0;
      1: new_len = STORE_DEPTH;
      2: new_len = 1;
      3, 4, 5, 6: new_len = $urandom_range(2, 6);
      default: new_len = $urandom_range(7, STORE_DEPTH - 1);
    endcase
    if (phase == 0) begin
      new_len = STORE_DEPTH;
    end
    new_ci  = 1'($urandom_range(0, 1));
    refresh = 1'($urandom_range(0, 1));

    // every position below the new length is loaded before any text byte reads it
    for (int i = 0; i < new_len; i++) begin
      if (!pat_loaded[i] || refresh) begin
        it = '0;
        it.action   = ACT_LOAD;
        it.value    = pick_char();
        it.position = POS_W'(i);
        send_item(it, 1'b0, '0);
      end
    end

    drain(SETTLE);
    ci_data    = CFG_DATA_W'($urandom_range(0, 31));
    ci_data[0] = new_ci;
    write_reg(REG_CASE_INS, ci_data);
    write_reg(REG_PAT_LEN, CFG_DATA_W'(new_len));

    n_texts = $urandom_range(1, 4);
    for (int t = 0; t < n_texts; t++) begin
      chunk.delete();
      target = $urandom_range(1, 10);
      if (pat_len > 0 && $urandom_range(0, 3) != 0) begin
        target += pat_len;
      end
      while (chunk.size() < target) begin
        if (pat_len > 0 && $urandom_range(0, 2) == 0) begin
          // pattern copy, letters flipped at random, sometimes one byte broken
          bad = ($urandom_range(0, 4) == 0) ? $urandom_range(0, pat_len - 1) : -1;
          for (int i = 0; i < pat_len; i++) begin
            c = pat_copy[i];
            if ($urandom_range(0, 2) == 0) begin
              c = swap_case(c);
            end
            if (i == bad) begin
              c = pick_char();
            end
            chunk.push_back(c);
          end
        end else if (pat_len > 0 && $urandom_range(0, 1) == 0) begin
          chunk.push_back(pat_copy[POS_W'($urandom_range(0, pat_len - 1))]);
        end else begin
          chunk.push_back(pick_char());
        end
      end

      skip_first = ($urandom_range(0, 9) == 0);
      foreach (chunk[j]) begin
        // occasional load in the middle of a text, in or out of range
        if ($urandom_range(0, 24) == 0) begin
          it = '0;
          it.action   = ACT_LOAD;
          it.value    = 8'($urandom_range(0, 255));
          it.position = POS_W'($urandom_range(0, 31));
          send_item(it, 1'b0, '0);
        end
        it.action     = ACT_TEXT;
        it.value      = chunk[j];
        it.position   = POS_W'($urandom_range(0, 31));
        it.text_first = (j == 0) ? !skip_first : ($urandom_range(0, 39) == 0);
        it.text_last  = (j == chunk.size() - 1) ? 1'b1 : ($urandom_range(0, 29) == 0);
        send_item(it, 1'b0, '0);
      end
    end
  endtask

  // Receiver stall pattern: spans of always-ready, mostly-ready, mostly-stalled, periodic
  always @(posedge clk) begin
    if (rx_span == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_span = $urandom_range(16, 96);
    end
    rx_span--;
    rx_tick++;
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ((rx_tick % 5) < 3);
    endcase
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (verdict_q.size() == 0) begin
        $error("result transfer with no expectation pending");
        fail_cnt++;
      end else begin
        want_now = verdict_q.pop_front();
        if (out_match_end !== want_now.match_end) begin
          $error("match_end: expected %0b, actual %0b", want_now.match_end, out_match_end);
          fail_cnt++;
        end
        if (out_found !== want_now.found) begin
          $error("found: expected %0b, actual %0b", want_now.found, out_found);
          fail_cnt++;
        end
        if (out_last !== want_now.last) begin
          $error("last: expected %0b, actual %0b", want_now.last, out_last);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      pat_copy[i] = '0;
    end
    pat_loaded = '0;
    hit_vec    = '0;
    found_seen = 1'b0;
    ci_mode    = 1'b0;
    pat_len    = '0;

    // empty pattern after reset, then "aBc" with a load past the store
    plan.push_back(txt_k(8'h00, 1'b1, 1'b0, 1'b0, 1'b1));
    plan.push_back(txt_k(8'hFF, 1'b0, 1'b1, 1'b0, 1'b1));
    plan.push_back(ld(8'h61, 5'd0));
    plan.push_back(ld(8'h42, 5'd1));
    plan.push_back(ld(8'h63, 5'd2));
    plan.push_back(ld(8'hFF, 5'd31));
    plan.push_back(ld(8'h00, 5'd30));
    plan.push_back(reg_row(REG_PAT_LEN, 5'd3));
    plan.push_back(txt_k(8'h78, 1'b1, 1'b0, 1'b0, 1'b0));
    plan.push_back(txt_k(8'h61, 1'b0, 1'b0, 1'b0, 1'b0));
    plan.push_back(txt_k(8'h42, 1'b0, 1'b0, 1'b0, 1'b0));
    plan.push_back(txt_k(8'h63, 1'b0, 1'b1, 1'b1, 1'b1));
    // no text_first: found stays set across the text_last boundary
    plan.push_back(txt_k(8'h61, 1'b0, 1'b0, 1'b0, 1'b1));
    // exact compare rejects the other case
    plan.push_back(txt_k(8'h41, 1'b1, 1'b0, 1'b0, 1'b0));
    plan.push_back(txt_k(8'h62, 1'b0, 1'b0, 1'b0, 1'b0));
    plan.push_back(txt_k(8'h43, 1'b0, 1'b1, 1'b0, 1'b0));
    // case folding on
    plan.push_back(reg_row(REG_CASE_INS, 5'd1));
    plan.push_back(txt(8'h41, 1'b1, 1'b0));
    plan.push_back(txt(8'h62, 1'b0, 1'b0));
    plan.push_back(txt_k(8'h43, 1'b0, 1'b1, 1'b1, 1'b1));
    plan.push_back(reg_row(REG_PAT_LEN, 5'd1));
    plan.push_back(txt_k(8'h41, 1'b1, 1'b1, 1'b1, 1'b1));
    plan.push_back(txt(8'h40, 1'b1, 1'b0));
    plan.push_back(reg_row(REG_PAT_LEN, 5'd0));
    plan.push_back(txt_k(8'h61, 1'b1, 1'b1, 1'b0, 1'b1));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_REG) begin
        drain(SETTLE);
        write_reg(plan[k].reg_idx, plan[k].reg_data);
      end else begin
        send_item(plan[k].item, plan[k].typed, plan[k].want);
      end
    end

    sent_count = 0;
    for (int p = 0; sent_count < RUN_ITEMS; p++) begin
      run_phase(p);
    end

    drain(SETTLE * 2);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== shift_and_substring_matcher_core.f =====
hdl/shsm_pkg.sv
hdl/shsm_pattern_store.sv
hdl/shsm_match_core.sv
hdl/shift_and_substring_matcher_core.sv
hdl/shsm_checker.sv
bench/testbench.sv
